// ===== design/conv3_pkg.sv =====
// Shared types, constants and register codes for the 3x3 RGB convolution block.
`timescale 1ns / 1ps
`default_nettype none
package conv3_pkg;

	localparam int MAX_WIDTH_DEF = 2048;
	localparam int QUEUE_DEPTH   = 4;
	localparam int OUT_DEPTH     = 8;

	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;
	localparam int WIDTH_REG_W = 12;
	localparam int HEIGHT_W    = 16;
	localparam int CX_W        = 11;
	localparam int KROW_W      = 24;
	localparam int CH_W        = 8;

	localparam logic [KROW_W-1:0] KERNEL_MID_RESET = 24'h000100;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_KERNEL_TOP   = 3'd2,
		REG_KERNEL_MID   = 3'd3,
		REG_KERNEL_BOT   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [CH_W-1:0] pixel_alpha;
		logic [CH_W-1:0] pixel_blue;
		logic [CH_W-1:0] pixel_green;
		logic [CH_W-1:0] pixel_red;
	} pixel_t;

	typedef struct packed {
		logic [CX_W-1:0]     center_x;
		logic [HEIGHT_W-1:0] center_y;
		logic [CH_W-1:0]     out_red;
		logic [CH_W-1:0]     out_green;
		logic [CH_W-1:0]     out_blue;
		logic [CH_W-1:0]     out_alpha;
		logic                frame_last;
	} result_t;

	// Classification that travels with each pixel from the front end
	typedef struct packed {
		logic                emit;
		logic [CX_W-1:0]     center_x;
		logic [HEIGHT_W-1:0] center_y;
		logic                frame_last;
	} tag_t;

	typedef struct packed {
		logic [KROW_W-1:0] row_bot;
		logic [KROW_W-1:0] row_mid;
		logic [KROW_W-1:0] row_top;
	} kernel_t;

endpackage
`default_nettype wire

// ===== design/conv3_front.sv =====
// Front end: raster position counters, pixel classification and the hand-off queue.
`timescale 1ns / 1ps
`default_nettype none
module conv3_front #(
	parameter int MAX_WIDTH = conv3_pkg::MAX_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  conv3_pkg::pixel_t                   pixel,
	input  logic [conv3_pkg::WIDTH_REG_W-1:0]   image_width,
	input  logic [conv3_pkg::HEIGHT_W-1:0]      image_height,
	output logic                                q_valid,
	input  logic                                q_pop,
	output conv3_pkg::pixel_t                   q_pixel,
	output logic [$clog2(MAX_WIDTH)-1:0]        q_col,
	output conv3_pkg::tag_t                     q_tag
);
	import conv3_pkg::*;

	localparam int XW  = $clog2(MAX_WIDTH);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int CW  = ((WW > WIDTH_REG_W) ? WW : WIDTH_REG_W) + 1;
	localparam int QAW = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		pixel_t        pix;
		logic [XW-1:0] col;
		tag_t          tag;
	} qent_t;

	logic [XW-1:0]       x_q;
	logic [HEIGHT_W-1:0] y_q;
	logic [CW-1:0]       w_lim;
	logic [CW-1:0]       x_ext;
	logic [CW-1:0]       x_inc;
	logic [HEIGHT_W:0]   y_inc;
	logic [HEIGHT_W:0]   h_ext;
	logic                accept;
	tag_t                acc_tag;

	qent_t               q_mem [QUEUE_DEPTH];
	logic [QAW-1:0]      wr_ptr_q;
	logic [QAW-1:0]      rd_ptr_q;
	logic [QCW-1:0]      count_q;
	qent_t               head;

	assign full    = (count_q == QCW'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign accept  = push && !full;

	always_comb begin
		w_lim = (CW'(image_width) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(image_width);
		x_ext = CW'(x_q);
		x_inc = x_ext + 1'b1;
		y_inc = {1'b0, y_q} + 1'b1;
		h_ext = {1'b0, image_height};
		acc_tag.emit = (x_ext >= CW'(2)) && (y_q >= HEIGHT_W'(2)) &&
			(x_ext < w_lim) && ({1'b0, y_q} < h_ext);
		acc_tag.center_x   = CX_W'(x_q - 1'b1);
		acc_tag.center_y   = y_q - 1'b1;
		acc_tag.frame_last = (x_inc == w_lim) && (y_inc == h_ext);
	end

	// Advance the raster position, wrapping at the configured sizes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
		end else if (accept) begin
			if (x_inc >= w_lim) begin
				x_q <= '0;
				y_q <= (y_inc >= h_ext) ? '0 : HEIGHT_W'(y_inc);
			end else begin
				x_q <= XW'(x_inc);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			q_mem[wr_ptr_q] <= '{pix: pixel, col: x_q, tag: acc_tag};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (accept && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!accept && q_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head    = q_mem[rd_ptr_q];
	assign q_pixel = head.pix;
	assign q_col   = head.col;
	assign q_tag   = head.tag;

endmodule
`default_nettype wire

// ===== design/conv3_back.sv =====
// Back end: line stores, 3x3 window, multiply-accumulate and saturation pipeline.
`timescale 1ns / 1ps
`default_nettype none
module conv3_back #(
	parameter int MAX_WIDTH = conv3_pkg::MAX_WIDTH_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      q_valid,
	output logic                                      q_pop,
	input  conv3_pkg::pixel_t                         q_pixel,
	input  logic [$clog2(MAX_WIDTH)-1:0]              q_col,
	input  conv3_pkg::tag_t                           q_tag,
	input  conv3_pkg::kernel_t                        kernel,
	input  logic [$clog2(conv3_pkg::OUT_DEPTH+1)-1:0] fifo_count,
	output logic                                      res_push,
	output conv3_pkg::result_t                        res
);
	import conv3_pkg::*;

	localparam int XW  = $clog2(MAX_WIDTH);
	localparam int OCW = $clog2(OUT_DEPTH + 1);
	localparam int PW  = 2 * CH_W + 1;
	localparam int SW  = PW + 3;

	function automatic logic [CH_W-1:0] chan(input pixel_t p, input int k);
		logic [CH_W-1:0] v;
		case (k)
			0:       v = p.pixel_red;
			1:       v = p.pixel_green;
			default: v = p.pixel_blue;
		endcase
		return v;
	endfunction

	function automatic logic [CH_W-1:0] sat(input logic signed [SW-1:0] s);
		logic [CH_W-1:0] v;
		if (s < 0) begin
			v = '0;
		end else if (s > SW'(255)) begin
			v = CH_W'(255);
		end else begin
			v = s[CH_W-1:0];
		end
		return v;
	endfunction

	// stage 1: popped from the queue, line store read issued
	logic                v_s1;
	pixel_t              pix_s1;
	logic [XW-1:0]       col_s1;
	tag_t                tag_s1;
	// stage 2: line store data back, store write and window shift
	logic                v_s2;
	pixel_t              pix_s2;
	logic [XW-1:0]       col_s2;
	tag_t                tag_s2;
	pixel_t              rd0_s2;
	pixel_t              rd1_s2;
	logic                fwd_s2;
	pixel_t              fwd0_s2;
	pixel_t              fwd1_s2;
	pixel_t              l0_eff;
	pixel_t              l1_eff;
	// stage 3: window holds this item's neighborhood
	pixel_t              window_q [3][3];
	logic                v_s3;
	tag_t                tag_s3;
	// stage 4: products; stage 5: channel sums
	logic signed [PW-1:0] prod_d  [3][3][3];
	logic signed [PW-1:0] prod_s4 [3][3][3];
	logic                 v_s4;
	tag_t                 tag_s4;
	logic [CH_W-1:0]      alpha_s4;
	logic signed [SW-1:0] sum_d  [3];
	logic signed [SW-1:0] sum_s5 [3];
	logic                 v_s5;
	tag_t                 tag_s5;
	logic [CH_W-1:0]      alpha_s5;

	pixel_t              mem0 [MAX_WIDTH];
	pixel_t              mem1 [MAX_WIDTH];

	logic signed [CH_W-1:0] coef [3][3];
	logic [OCW:0]           used;

	// Hold off the queue unless every result in flight has an output slot
	always_comb begin
		used = (OCW + 1)'(fifo_count) + (OCW + 1)'($countones({v_s1 & tag_s1.emit,
			v_s2 & tag_s2.emit, v_s3 & tag_s3.emit, v_s4 & tag_s4.emit,
			v_s5 & tag_s5.emit}));
		q_pop = q_valid && (used < (OCW + 1)'(OUT_DEPTH));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			fwd_s2 <= 1'b0;
		end else begin
			v_s1 <= q_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			fwd_s2 <= v_s1 && v_s2 && (col_s1 == col_s2);
		end
	end

	always_ff @(posedge clk) begin
		pix_s1   <= q_pixel;
		col_s1   <= q_col;
		tag_s1   <= q_tag;
		pix_s2   <= pix_s1;
		col_s2   <= col_s1;
		tag_s2   <= tag_s1;
		fwd0_s2  <= pix_s2;
		fwd1_s2  <= l0_eff;
		tag_s3   <= tag_s2;
		tag_s4   <= tag_s3;
		alpha_s4 <= window_q[1][1].pixel_alpha;
		tag_s5   <= tag_s4;
		alpha_s5 <= alpha_s4;
		prod_s4  <= prod_d;
		sum_s5   <= sum_d;
	end

	// Line stores: row above in mem0, two rows above in mem1
	always_ff @(posedge clk) begin
		rd0_s2 <= mem0[col_s1];
		rd1_s2 <= mem1[col_s1];
		if (v_s2) begin
			mem0[col_s2] <= pix_s2;
			mem1[col_s2] <= l0_eff;
		end
	end

	// Take the just-written data when the previous pixel hit the same column
	assign l0_eff = fwd_s2 ? fwd0_s2 : rd0_s2;
	assign l1_eff = fwd_s2 ? fwd1_s2 : rd1_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					window_q[r][c] <= '0;
				end
			end
		end else if (v_s2) begin
			for (int r = 0; r < 3; r++) begin
				window_q[r][0] <= window_q[r][1];
				window_q[r][1] <= window_q[r][2];
			end
			window_q[0][2] <= l1_eff;
			window_q[1][2] <= l0_eff;
			window_q[2][2] <= pix_s2;
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			coef[0][c] = kernel.row_top[8*c +: 8];
			coef[1][c] = kernel.row_mid[8*c +: 8];
			coef[2][c] = kernel.row_bot[8*c +: 8];
		end
		for (int k = 0; k < 3; k++) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_d[k][r][c] = PW'($signed({1'b0, chan(window_q[r][c], k)}))
						* PW'(coef[r][c]);
				end
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sum_d[k] = (SW'(prod_s4[k][0][0]) + SW'(prod_s4[k][0][1]) + SW'(prod_s4[k][0][2]))
				+ (SW'(prod_s4[k][1][0]) + SW'(prod_s4[k][1][1]) + SW'(prod_s4[k][1][2]))
				+ (SW'(prod_s4[k][2][0]) + SW'(prod_s4[k][2][1]) + SW'(prod_s4[k][2][2]));
		end
	end

	assign res_push       = v_s5 && tag_s5.emit;
	assign res.center_x   = tag_s5.center_x;
	assign res.center_y   = tag_s5.center_y;
	assign res.out_red    = sat(sum_s5[0]);
	assign res.out_green  = sat(sum_s5[1]);
	assign res.out_blue   = sat(sum_s5[2]);
	assign res.out_alpha  = alpha_s5;
	assign res.frame_last = tag_s5.frame_last;

`ifndef SYNTHESIS
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("queue popped while empty");
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		used <= (OCW + 1)'(OUT_DEPTH))
		else $error("results in flight exceed output queue space");
	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |=> window_q[2][2] == $past(pix_s2))
		else $error("window did not take the new pixel");
	a_fwd: assert property (@(posedge clk) disable iff (!arst_n) fwd_s2 |-> v_s2)
		else $error("forward flag without a pixel in stage 2");
`endif

endmodule
`default_nettype wire

// ===== design/conv3_ofifo.sv =====
// Output queue holding finished results until the receiver takes them.
`timescale 1ns / 1ps
`default_nettype none
module conv3_ofifo (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      push,
	input  conv3_pkg::result_t                        din,
	input  logic                                      pop,
	output logic                                      empty,
	output conv3_pkg::result_t                        dout,
	output logic [$clog2(conv3_pkg::OUT_DEPTH+1)-1:0] count
);
	import conv3_pkg::*;

	localparam int AW = $clog2(OUT_DEPTH);
	localparam int CW = $clog2(OUT_DEPTH + 1);

	result_t        mem [OUT_DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_pop;

	assign empty  = (count_q == '0);
	assign do_pop = pop && !empty;
	assign count  = count_q;
	assign dout   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/conv3x3_rgb_saturating.sv =====
// Top level of the streaming 3x3 RGB convolution filter with saturation.
//
// Usage: write image_width, image_height and the three kernel rows through
// cfg_we/cfg_index/cfg_data while the block is idle. Then push RGBA pixels in
// raster order; a transaction on the input side happens when push is high and
// full is low. For every interior pixel (not on the image border) one result
// appears on the output side: result is valid while empty is low and is taken
// by a pop transaction. frame_last marks the last interior pixel of a frame.
// Throughput: one pixel per clock while the output queue has room for the
// results in flight. Each line store does one read and one write per cycle,
// and the multiply-accumulate is fully pipelined. A result passes through the
// input queue, line store read, window update, products, sums and output
// queue after the transaction of the pixel that completes its window.
// Reset: counters return to the top-left corner, the kernel becomes identity
// (centre coefficient 1), width and height become 0; the line stores are not
// cleared and need no clearing pass.
// Receiver stall: results collect in an 8-entry output queue; the back end
// stops draining the 4-entry input queue when queued plus in-flight results
// would fill it, and full rises once the input queue fills.
`timescale 1ns / 1ps
`default_nettype none
module conv3x3_rgb_saturating #(
	parameter int MAX_WIDTH = conv3_pkg::MAX_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  conv3_pkg::pixel_t                   pixel,
	output logic                                empty,
	input  logic                                pop,
	output conv3_pkg::result_t                  result,
	input  logic                                cfg_we,
	input  logic [conv3_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [conv3_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import conv3_pkg::*;

	localparam int XW  = $clog2(MAX_WIDTH);
	localparam int OCW = $clog2(OUT_DEPTH + 1);

	// Configuration registers
	logic [WIDTH_REG_W-1:0] width_q;
	logic [HEIGHT_W-1:0]    height_q;
	kernel_t                kernel_q;

	// Front to back hand-off
	logic          q_valid;
	logic          q_pop;
	pixel_t        q_pixel;
	logic [XW-1:0] q_col;
	tag_t          q_tag;

	// Back to output queue
	logic          res_push;
	result_t       res;
	logic [OCW-1:0] fifo_count;

	// Decode register writes; an unknown index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q          <= '0;
			height_q         <= '0;
			kernel_q.row_top <= '0;
			kernel_q.row_mid <= KERNEL_MID_RESET;
			kernel_q.row_bot <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:  width_q          <= cfg_data[WIDTH_REG_W-1:0];
				REG_IMAGE_HEIGHT: height_q         <= cfg_data[HEIGHT_W-1:0];
				REG_KERNEL_TOP:   kernel_q.row_top <= cfg_data[KROW_W-1:0];
				REG_KERNEL_MID:   kernel_q.row_mid <= cfg_data[KROW_W-1:0];
				REG_KERNEL_BOT:   kernel_q.row_bot <= cfg_data[KROW_W-1:0];
				default: ;
			endcase
		end
	end

	conv3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.pixel        (pixel),
		.image_width  (width_q),
		.image_height (height_q),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_pixel      (q_pixel),
		.q_col        (q_col),
		.q_tag        (q_tag)
	);

	conv3_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_pixel    (q_pixel),
		.q_col      (q_col),
		.q_tag      (q_tag),
		.kernel     (kernel_q),
		.fifo_count (fifo_count),
		.res_push   (res_push),
		.res        (res)
	);

	conv3_ofifo u_ofifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res),
		.pop    (pop),
		.empty  (empty),
		.dout   (result),
		.count  (fifo_count)
	);

endmodule
`default_nettype wire

// ===== verif/conv3_result_checker.sv =====
// Result checker for the 3x3 RGB convolution block: predicts every filtered pixel and compares.
`timescale 1ns / 1ps
module conv3_result_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  logic                                full,
	input  conv3_pkg::pixel_t                   pixel,
	input  logic                                empty,
	input  logic                                pop,
	input  conv3_pkg::result_t                  result,
	input  logic                                cfg_we,
	input  logic [conv3_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [conv3_pkg::CFG_DATA_W-1:0]    cfg_data,
	output int                                  mismatches,
	output int                                  results_owed
);
	import conv3_pkg::*;

	logic [WIDTH_REG_W-1:0] width_reg;
	logic [HEIGHT_W-1:0]    height_reg;
	logic [KROW_W-1:0]      kern [3];

	// row_above holds row y-1, row_two_above holds row y-2
	pixel_t row_above     [MAX_WIDTH_DEF];
	pixel_t row_two_above [MAX_WIDTH_DEF];
	pixel_t win [3][3];
	int     col_pos;
	int     row_pos;

	result_t owed_q [$];

	// Signed multiply-accumulate over the window for one channel, clamped to a byte
	function automatic logic [CH_W-1:0] filtered_channel(input int ch);
		int acc;
		int sample;
		int coef;
		acc = 0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				sample = win[r][c][CH_W*ch +: CH_W];
				coef = $signed(kern[r][CH_W*c +: CH_W]);
				acc += sample * coef;
			end
		end
		if (acc < 0)
			return '0;
		if (acc > 255)
			return 8'd255;
		return acc[CH_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		int      eff_w;
		int      col;
		result_t owed;
		if (!arst_n) begin
			width_reg = '0;
			height_reg = '0;
			kern[0] = '0;
			kern[1] = KERNEL_MID_RESET;
			kern[2] = '0;
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					win[r][c] = '0;
			col_pos = 0;
			row_pos = 0;
			owed_q.delete();
			mismatches = 0;
			results_owed <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_IMAGE_WIDTH:  width_reg = cfg_data[WIDTH_REG_W-1:0];
					REG_IMAGE_HEIGHT: height_reg = cfg_data[HEIGHT_W-1:0];
					REG_KERNEL_TOP:   kern[0] = cfg_data[KROW_W-1:0];
					REG_KERNEL_MID:   kern[1] = cfg_data[KROW_W-1:0];
					REG_KERNEL_BOT:   kern[2] = cfg_data[KROW_W-1:0];
					default: ;
				endcase
			end

			if (push && !full) begin
				eff_w = (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(width_reg);
				col = (col_pos < MAX_WIDTH_DEF) ? col_pos : MAX_WIDTH_DEF - 1;
				// Slide the window left, pull the new column from the line stores
				for (int r = 0; r < 3; r++) begin
					win[r][0] = win[r][1];
					win[r][1] = win[r][2];
				end
				win[0][2] = row_two_above[col];
				win[1][2] = row_above[col];
				win[2][2] = pixel;
				row_two_above[col] = row_above[col];
				row_above[col] = pixel;

				if (col_pos >= 2 && row_pos >= 2 && col_pos < eff_w &&
						row_pos < int'(height_reg)) begin
					owed.center_x = CX_W'(col_pos - 1);
					owed.center_y = HEIGHT_W'(row_pos - 1);
					owed.out_red = filtered_channel(0);
					owed.out_green = filtered_channel(1);
					owed.out_blue = filtered_channel(2);
					owed.out_alpha = win[1][1].pixel_alpha;
					owed.frame_last = (col_pos + 1 == eff_w) &&
						(row_pos + 1 == int'(height_reg));
					owed_q.push_back(owed);
				end

				col_pos++;
				if (col_pos >= eff_w) begin
					col_pos = 0;
					row_pos++;
					if (row_pos >= int'(height_reg))
						row_pos = 0;
				end
			end

			if (pop && !empty) begin
				if (owed_q.size() == 0) begin
					mismatches++;
					$display("%0t: result x=%0d y=%0d arrived with nothing expected",
						$time, result.center_x, result.center_y);
				end else begin
					owed = owed_q.pop_front();
					if (result.center_x !== owed.center_x) begin
						mismatches++;
						$display("%0t: center_x expected %0d, got %0d",
							$time, owed.center_x, result.center_x);
					end
					if (result.center_y !== owed.center_y) begin
						mismatches++;
						$display("%0t: center_y expected %0d, got %0d",
							$time, owed.center_y, result.center_y);
					end
					if (result.out_red !== owed.out_red) begin
						mismatches++;
						$display("%0t: out_red at (%0d,%0d) expected %0d, got %0d", $time,
							owed.center_x, owed.center_y, owed.out_red, result.out_red);
					end
					if (result.out_green !== owed.out_green) begin
						mismatches++;
						$display("%0t: out_green at (%0d,%0d) expected %0d, got %0d", $time,
							owed.center_x, owed.center_y, owed.out_green, result.out_green);
					end
					if (result.out_blue !== owed.out_blue) begin
						mismatches++;
						$display("%0t: out_blue at (%0d,%0d) expected %0d, got %0d", $time,
							owed.center_x, owed.center_y, owed.out_blue, result.out_blue);
					end
					if (result.out_alpha !== owed.out_alpha) begin
						mismatches++;
						$display("%0t: out_alpha at (%0d,%0d) expected %0d, got %0d", $time,
							owed.center_x, owed.center_y, owed.out_alpha, result.out_alpha);
					end
					if (result.frame_last !== owed.frame_last) begin
						mismatches++;
						$display("%0t: frame_last at (%0d,%0d) expected %0b, got %0b", $time,
							owed.center_x, owed.center_y, owed.frame_last, result.frame_last);
					end
				end
			end

			results_owed <= owed_q.size();
		end
	end

endmodule

// ===== verif/tb_conv3x3_rgb_saturating.sv =====
// Testbench top for the 3x3 RGB convolution block: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_conv3x3_rgb_saturating;
	import conv3_pkg::*;

	// No register lives at this index; a write to it must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

	// Cycles to let in-flight pixels that produce no result leave the pipeline
	// (input queue plus the five-stage datapath) before touching the registers
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_PIXELS = 1900;
	localparam int RUN_LIMIT_NS  = 5_000_000;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	typedef enum int {
		KERN_IDENTITY,
		KERN_RANDOM,
		KERN_SMALL,
		KERN_SHARPEN,
		KERN_EXTREME
	} kernel_kind_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push;
	logic                  full;
	pixel_t                pixel;
	logic                  empty;
	logic                  pop;
	result_t               result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int mismatches;
	int results_owed;
	int send_idle_pct = 0;
	int stall_pct = 0;

	always #6 clk = ~clk;

	conv3x3_rgb_saturating dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.pixel     (pixel),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	conv3_result_checker pixel_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.pixel        (pixel),
		.empty        (empty),
		.pop          (pop),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.results_owed (results_owed)
	);

	// Pick how often each side holds back for the coming phase
	task automatic set_pressure(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			IDLE_SENDER: begin
				send_idle_pct = 65;
				stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct = 0;
				stall_pct = 65;
			end
			default: begin
				send_idle_pct = 35;
				stall_pct = 35;
			end
		endcase
	endtask

	// Bias each channel toward its extremes, but keep plenty of arbitrary values
	function automatic logic [CH_W-1:0] rand_channel();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return CH_W'($urandom_range(255));
		endcase
	endfunction

	function automatic pixel_t rand_pixel();
		pixel_t p;
		p.pixel_red = rand_channel();
		p.pixel_green = rand_channel();
		p.pixel_blue = rand_channel();
		p.pixel_alpha = rand_channel();
		return p;
	endfunction

	function automatic logic [CH_W-1:0] rand_coef(input kernel_kind_t kind);
		logic [CH_W-1:0] v;
		case (kind)
			KERN_SMALL: begin
				// -2..2: sums that often land inside 0..255
				v = CH_W'($urandom_range(4));
				return v - 8'd2;
			end
			KERN_EXTREME: begin
				case ($urandom_range(4))
					0: return 8'h80;
					1: return 8'h7F;
					2: return 8'hFF;
					3: return 8'h01;
					default: return 8'h00;
				endcase
			end
			default: return CH_W'($urandom_range(255));
		endcase
	endfunction

	function automatic kernel_t rand_kernel();
		kernel_t k;
		kernel_kind_t kind;
		kind = kernel_kind_t'($urandom_range(4));
		case (kind)
			KERN_IDENTITY: begin
				k.row_top = '0;
				k.row_mid = KERNEL_MID_RESET;
				k.row_bot = '0;
			end
			KERN_SHARPEN: begin
				k.row_top = 24'h00FF00;
				k.row_mid = 24'hFF05FF;
				k.row_bot = 24'h00FF00;
			end
			default: begin
				for (int i = 0; i < 9; i++)
					k[CH_W*i +: CH_W] = rand_coef(kind);
			end
		endcase
		return k;
	endfunction

	// Pixels until the position counters are back at the top-left corner;
	// a zero size keeps its counter at zero
	function automatic int frame_len(input int w, input int h);
		return ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
	endfunction

	// Offer one pixel, maybe after a random gap, and hold it until a transaction.
	// Leave push high on return so back-to-back pixels never toggle it.
	task automatic send_pixel(input pixel_t p);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		push <= 1'b1;
		pixel <= p;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic send_pixels(input int count);
		repeat (count)
			send_pixel(rand_pixel());
	endtask

	// Drop push, wait for every predicted result, then let the pipeline empty
	task automatic wait_idle();
		push <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// Leave cfg_we high; the caller drops it after the last write of a group
	task automatic reg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic set_config(input int w, input int h, input kernel_t k);
		reg_write(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
		reg_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
		reg_write(REG_KERNEL_TOP, k.row_top);
		reg_write(REG_KERNEL_MID, k.row_mid);
		reg_write(REG_KERNEL_BOT, k.row_bot);
		cfg_we <= 1'b0;
	endtask

	// Receiver: pop at random according to the current stall rate
	initial begin
		pop <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			pop <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog: stop a hung run
	initial begin
		#(RUN_LIMIT_NS);
		$display("FAILURE");
		$finish;
	end

	initial begin
		kernel_t k;
		int      w;
		int      h;
		int      len;
		int      split;
		int      phase;
		int      random_sent;

		push <= 1'b0;
		pixel <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part
		set_pressure(IDLE_NONE);
		reg_write(REG_UNMAPPED, '1);

		// Smallest image with a result, extreme coefficients, saturated and clipped sums
		k.row_top = 24'h808080;
		k.row_mid = 24'h80FF7F;
		k.row_bot = 24'h7F7F7F;
		set_config(3, 3, k);
		send_pixel('1);
		send_pixel('0);
		send_pixels(7);
		wait_idle();

		// Images too small for any result; zero sizes pin their counter
		set_pressure(IDLE_SENDER);
		set_config(2, 3, rand_kernel());
		send_pixels(frame_len(2, 3));
		wait_idle();
		set_config(4, 1, rand_kernel());
		send_pixels(frame_len(4, 1));
		wait_idle();
		set_config(0, 2, rand_kernel());
		send_pixels(frame_len(0, 2));
		wait_idle();
		set_config(3, 0, rand_kernel());
		send_pixels(frame_len(3, 0));
		wait_idle();

		// Tallest frame with an all-minus-one kernel, then shrink the height
		// mid-frame below the current row: the rest of that row emits nothing
		// and the counters wrap back to the corner
		set_pressure(IDLE_RECEIVER);
		k.row_top = '1;
		k.row_mid = '1;
		k.row_bot = '1;
		set_config(5, 65535, k);
		send_pixels(20);
		wait_idle();
		k.row_top = '0;
		k.row_mid = KERNEL_MID_RESET;
		k.row_bot = '0;
		set_config(5, 2, k);
		send_pixels(5);
		wait_idle();

		// Random part: whole frames of random content, rotating the idle pattern,
		// sometimes with a kernel change halfway through a frame
		phase = 0;
		random_sent = 0;
		while (random_sent < RANDOM_PIXELS) begin
			set_pressure(idle_mode_t'(phase % 4));
			phase++;
			w = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
			h = $urandom_range(3, 8);
			if ($urandom_range(11) == 0) begin
				if ($urandom_range(1) == 0)
					w = $urandom_range(2);
				else
					h = $urandom_range(2);
			end
			len = frame_len(w, h);
			set_config(w, h, rand_kernel());
			repeat ($urandom_range(1, 2)) begin
				if (len > 4 && $urandom_range(3) == 0) begin
					split = $urandom_range(1, len - 1);
					send_pixels(split);
					wait_idle();
					set_config(w, h, rand_kernel());
					send_pixels(len - split);
				end else begin
					send_pixels(len);
				end
				random_sent += len;
			end
			wait_idle();
		end

		// wait_idle above already drained every result; give stragglers a chance
		repeat (2 * SETTLE_CYCLES)
			@(posedge clk);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
